@@ rtl/core/pimdc_pkg.sv @@
// Types and constants of the PI motor duty controller.
package pimdc_pkg;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_PI     = 11'b000_0000_0010,
      ST_ROUND  = 11'b000_0000_0100,
      ST_SUM    = 11'b000_0000_1000,
      ST_LIMIT  = 11'b000_0001_0000,
      ST_DMUL   = 11'b000_0010_0000,
      ST_DSCALE = 11'b000_0100_0000,
      ST_DDIV   = 11'b000_1000_0000,
      ST_LMUL   = 11'b001_0000_0000,
      ST_LDIV   = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

   localparam logic [2:0] CSR_COEF_CURRENT  = 3'd0;
   localparam logic [2:0] CSR_COEF_PREVIOUS = 3'd1;
   localparam logic [2:0] CSR_MIN_DUTY      = 3'd2;
   localparam logic [2:0] CSR_MAX_DUTY      = 3'd3;
   localparam logic [2:0] CSR_PWM_TOP       = 3'd4;

   localparam logic [23:0] COEF_CURRENT_RST  = 24'd4096;
   localparam logic [23:0] COEF_PREVIOUS_RST = 24'd0;
   localparam logic [14:0] MIN_DUTY_RST      = 15'd0;
   localparam logic [6:0]  MAX_DUTY_RST      = 7'd100;
   localparam logic [15:0] PWM_TOP_RST       = 16'd65534;

   localparam logic [6:0] DUTY_CEIL = 7'd100;

   // +/-90 percent in Q8.8
   localparam logic signed [36:0] SAT_HI_WIDE = 37'sd23040;
   localparam logic signed [36:0] SAT_LO_WIDE = -37'sd23040;
   localparam logic signed [15:0] SAT_HI      = 16'sd23040;
   localparam logic signed [15:0] SAT_LO      = -16'sd23040;

   // duty = floor(floor(P * 65534 / 1024) / 2500), level = floor(Y / 65535)
   localparam logic [15:0] DUTY_DIV  = 16'd2500;
   localparam logic [15:0] LEVEL_DIV = 16'd65535;

   localparam logic [43:0] ROUND_BIAS = 44'd128;

   localparam logic [4:0] PI_LAST   = 5'd16;
   localparam logic [4:0] DMUL_LAST = 5'd6;
   localparam logic [4:0] DIGIT_LAST = 5'd15;

endpackage

@@ rtl/core/pi_motor_duty_controller_top.sv @@
// PI motor duty controller: incremental PI law, kick, saturation and PWM levels.
//
// One word in, one word out. Each word passes from acceptance to the result
// register through a bit-serial multiply-accumulate over the present and
// previous error, rounding, accumulation and limiting, a bit-serial duty
// multiply, a scaling step, a radix-2 divider, a bit-serial level multiply
// and a second divider pass, then the load of the output register. A new word
// is taken only once the previous one has reached the output register; while
// the output stalls, the result waits and no new word is taken.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
module pi_motor_duty_controller_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_setpoint,
   input  logic signed [15:0] req_measured,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_control,
   output logic               rsp_forward,
   output logic        [15:0] rsp_level_a,
   output logic        [15:0] rsp_level_b,
   input  logic               csr_we,
   input  logic        [2:0]  csr_index,
   input  logic        [23:0] csr_wdata
);

   pimdc_pkg::state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [23:0] coef_current_ff, coef_current_in;
   logic [23:0] coef_previous_ff, coef_previous_in;
   logic [14:0] min_duty_ff, min_duty_in;
   logic [6:0]  max_duty_ff, max_duty_in;
   logic [15:0] pwm_top_ff, pwm_top_in;

   logic [16:0] last_error_ff, last_error_in;
   logic [15:0] last_control_ff, last_control_in;

   logic        sp_zero_ff, sp_zero_in;
   logic [16:0] e_sh_ff, e_sh_in;
   logic [16:0] le_sh_ff, le_sh_in;
   logic [25:0] acc_hi_ff, acc_hi_in;
   logic [16:0] acc_lo_ff, acc_lo_in;
   logic [35:0] rnd_ff, rnd_in;
   logic [36:0] raw_ff, raw_in;
   logic [15:0] ctl_ff, ctl_in;
   logic [31:0] mul_acc_ff, mul_acc_in;
   logic [31:0] mul_mc_ff, mul_mc_in;
   logic [15:0] mul_mp_ff, mul_mp_in;
   logic [15:0] div_rem_ff, div_rem_in;
   logic [15:0] div_q_ff, div_q_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_control_ff, rsp_control_in;
   logic        rsp_forward_ff, rsp_forward_in;
   logic [15:0] rsp_level_a_ff, rsp_level_a_in;
   logic [15:0] rsp_level_b_ff, rsp_level_b_in;

   logic [16:0] err;
   logic [25:0] pe;
   logic [25:0] pl;
   logic [25:0] part;
   logic [25:0] part_adj;
   logic [26:0] psum;
   logic [43:0] biased;
   logic [36:0] kick;
   logic [15:0] ctl;
   logic [15:0] ctl_neg;
   logic [14:0] mag;
   logic [21:0] prod_p;
   logic [37:0] scaled;
   logic [31:0] mul_sum;
   logic [15:0] divisor;
   logic [16:0] trial;
   logic [16:0] trial_sub;
   logic        take;
   logic [15:0] q_next;
   logic [6:0]  duty_wr;
   logic        out_free;

   assign req_ready   = (state_ff == pimdc_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_control = rsp_control_ff;
   assign rsp_forward = rsp_forward_ff;
   assign rsp_level_a = rsp_level_a_ff;
   assign rsp_level_b = rsp_level_b_ff;

   // datapath helpers
   assign err      = {req_setpoint[15], req_setpoint} - {req_measured[15], req_measured};
   assign pe       = e_sh_ff[0] ? {{2{coef_current_ff[23]}}, coef_current_ff} : 26'd0;
   assign pl       = le_sh_ff[0] ? {{2{coef_previous_ff[23]}}, coef_previous_ff} : 26'd0;
   assign part     = pe + pl;
   assign part_adj = (cnt_ff == pimdc_pkg::PI_LAST) ? (26'd0 - part) : part;
   assign psum     = {acc_hi_ff[25], acc_hi_ff} + {part_adj[25], part_adj};
   assign biased   = {acc_hi_ff[25], acc_hi_ff, acc_lo_ff} + pimdc_pkg::ROUND_BIAS;

   assign mul_sum  = mul_acc_ff + (mul_mp_ff[0] ? mul_mc_ff : 32'd0);
   assign prod_p   = mul_acc_ff[21:0];
   assign scaled   = {prod_p, 16'd0} - {15'd0, prod_p, 1'b0};

   assign divisor   = (state_ff == pimdc_pkg::ST_DDIV) ? pimdc_pkg::DUTY_DIV
                                                       : pimdc_pkg::LEVEL_DIV;
   assign trial     = {div_rem_ff, div_q_ff[15]};
   assign take      = (trial >= {1'b0, divisor});
   assign trial_sub = take ? (trial - {1'b0, divisor}) : trial;
   assign q_next    = {div_q_ff[14:0], take};

   assign duty_wr  = (csr_wdata[6:0] > pimdc_pkg::DUTY_CEIL) ? pimdc_pkg::DUTY_CEIL
                                                             : csr_wdata[6:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // kick and saturation
   always_comb begin
      if (last_control_ff == 16'd0) begin
         kick = raw_ff[36] ? (37'd0 - {22'd0, min_duty_ff}) : {22'd0, min_duty_ff};
      end else begin
         kick = raw_ff;
      end
      if (sp_zero_ff) begin
         ctl = 16'd0;
      end else if ($signed(kick) > pimdc_pkg::SAT_HI_WIDE) begin
         ctl = pimdc_pkg::SAT_HI;
      end else if ($signed(kick) < pimdc_pkg::SAT_LO_WIDE) begin
         ctl = pimdc_pkg::SAT_LO;
      end else begin
         ctl = kick[15:0];
      end
      ctl_neg = 16'd0 - ctl;
      mag     = ctl[15] ? ctl_neg[14:0] : ctl[14:0];
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      coef_current_in  = coef_current_ff;
      coef_previous_in = coef_previous_ff;
      min_duty_in      = min_duty_ff;
      max_duty_in      = max_duty_ff;
      pwm_top_in       = pwm_top_ff;
      last_error_in    = last_error_ff;
      last_control_in  = last_control_ff;
      sp_zero_in       = sp_zero_ff;
      e_sh_in          = e_sh_ff;
      le_sh_in         = le_sh_ff;
      acc_hi_in        = acc_hi_ff;
      acc_lo_in        = acc_lo_ff;
      rnd_in           = rnd_ff;
      raw_in           = raw_ff;
      ctl_in           = ctl_ff;
      mul_acc_in       = mul_acc_ff;
      mul_mc_in        = mul_mc_ff;
      mul_mp_in        = mul_mp_ff;
      div_rem_in       = div_rem_ff;
      div_q_in         = div_q_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_control_in   = rsp_control_ff;
      rsp_forward_in   = rsp_forward_ff;
      rsp_level_a_in   = rsp_level_a_ff;
      rsp_level_b_in   = rsp_level_b_ff;

      if (csr_we) begin
         case (csr_index)
            pimdc_pkg::CSR_COEF_CURRENT:  coef_current_in  = csr_wdata;
            pimdc_pkg::CSR_COEF_PREVIOUS: coef_previous_in = csr_wdata;
            pimdc_pkg::CSR_MIN_DUTY:      min_duty_in      = csr_wdata[14:0];
            pimdc_pkg::CSR_MAX_DUTY:      max_duty_in      = duty_wr;
            pimdc_pkg::CSR_PWM_TOP:       pwm_top_in       = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         pimdc_pkg::ST_IDLE: begin
            if (req_valid) begin
               sp_zero_in    = (req_setpoint == 16'sd0);
               e_sh_in       = err;
               le_sh_in      = last_error_ff;
               last_error_in = err;
               acc_hi_in     = 26'd0;
               acc_lo_in     = 17'd0;
               cnt_in        = 5'd0;
               state_in      = pimdc_pkg::ST_PI;
            end
         end
         pimdc_pkg::ST_PI: begin
            acc_hi_in = psum[26:1];
            acc_lo_in = {psum[0], acc_lo_ff[16:1]};
            e_sh_in   = {1'b0, e_sh_ff[16:1]};
            le_sh_in  = {1'b0, le_sh_ff[16:1]};
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == pimdc_pkg::PI_LAST) begin
               state_in = pimdc_pkg::ST_ROUND;
            end
         end
         pimdc_pkg::ST_ROUND: begin
            rnd_in   = biased[43:8];
            state_in = pimdc_pkg::ST_SUM;
         end
         pimdc_pkg::ST_SUM: begin
            raw_in   = {rnd_ff[35], rnd_ff} + {{21{last_control_ff[15]}}, last_control_ff};
            state_in = pimdc_pkg::ST_LIMIT;
         end
         pimdc_pkg::ST_LIMIT: begin
            ctl_in          = ctl;
            last_control_in = ctl;
            mul_acc_in      = 32'd0;
            mul_mc_in       = {17'd0, mag};
            mul_mp_in       = {9'd0, max_duty_ff};
            cnt_in          = 5'd0;
            state_in        = pimdc_pkg::ST_DMUL;
         end
         pimdc_pkg::ST_DMUL: begin
            mul_acc_in = mul_sum;
            mul_mc_in  = {mul_mc_ff[30:0], 1'b0};
            mul_mp_in  = {1'b0, mul_mp_ff[15:1]};
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == pimdc_pkg::DMUL_LAST) begin
               state_in = pimdc_pkg::ST_DSCALE;
            end
         end
         pimdc_pkg::ST_DSCALE: begin
            div_rem_in = {4'd0, scaled[37:26]};
            div_q_in   = scaled[25:10];
            cnt_in     = 5'd0;
            state_in   = pimdc_pkg::ST_DDIV;
         end
         pimdc_pkg::ST_DDIV: begin
            div_rem_in = trial_sub[15:0];
            div_q_in   = q_next;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == pimdc_pkg::DIGIT_LAST) begin
               mul_acc_in = 32'd0;
               mul_mc_in  = {15'd0, {1'b0, pwm_top_ff} + 17'd1};
               mul_mp_in  = q_next;
               cnt_in     = 5'd0;
               state_in   = pimdc_pkg::ST_LMUL;
            end
         end
         pimdc_pkg::ST_LMUL: begin
            mul_acc_in = mul_sum;
            mul_mc_in  = {mul_mc_ff[30:0], 1'b0};
            mul_mp_in  = {1'b0, mul_mp_ff[15:1]};
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == pimdc_pkg::DIGIT_LAST) begin
               div_rem_in = mul_sum[31:16];
               div_q_in   = mul_sum[15:0];
               cnt_in     = 5'd0;
               state_in   = pimdc_pkg::ST_LDIV;
            end
         end
         pimdc_pkg::ST_LDIV: begin
            div_rem_in = trial_sub[15:0];
            div_q_in   = q_next;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == pimdc_pkg::DIGIT_LAST) begin
               state_in = pimdc_pkg::ST_OUT;
            end
         end
         pimdc_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_control_in = ctl_ff;
               rsp_forward_in = !ctl_ff[15];
               rsp_level_a_in = ctl_ff[15] ? 16'd0 : div_q_ff;
               rsp_level_b_in = ctl_ff[15] ? div_q_ff : 16'd0;
               state_in       = pimdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pimdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pimdc_pkg::ST_IDLE;
         cnt_ff           <= 5'd0;
         coef_current_ff  <= pimdc_pkg::COEF_CURRENT_RST;
         coef_previous_ff <= pimdc_pkg::COEF_PREVIOUS_RST;
         min_duty_ff      <= pimdc_pkg::MIN_DUTY_RST;
         max_duty_ff      <= pimdc_pkg::MAX_DUTY_RST;
         pwm_top_ff       <= pimdc_pkg::PWM_TOP_RST;
         last_error_ff    <= 17'd0;
         last_control_ff  <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         coef_current_ff  <= coef_current_in;
         coef_previous_ff <= coef_previous_in;
         min_duty_ff      <= min_duty_in;
         max_duty_ff      <= max_duty_in;
         pwm_top_ff       <= pwm_top_in;
         last_error_ff    <= last_error_in;
         last_control_ff  <= last_control_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_zero_ff     <= sp_zero_in;
      e_sh_ff        <= e_sh_in;
      le_sh_ff       <= le_sh_in;
      acc_hi_ff      <= acc_hi_in;
      acc_lo_ff      <= acc_lo_in;
      rnd_ff         <= rnd_in;
      raw_ff         <= raw_in;
      ctl_ff         <= ctl_in;
      mul_acc_ff     <= mul_acc_in;
      mul_mc_ff      <= mul_mc_in;
      mul_mp_ff      <= mul_mp_in;
      div_rem_ff     <= div_rem_in;
      div_q_ff       <= div_q_in;
      rsp_control_ff <= rsp_control_in;
      rsp_forward_ff <= rsp_forward_in;
      rsp_level_a_ff <= rsp_level_a_in;
      rsp_level_b_ff <= rsp_level_b_in;
   end

`ifndef SYNTHESIS
   a_levels_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_a_ff == 16'd0 || rsp_level_b_ff == 16'd0))
      else $error("both channel levels nonzero");

   a_control_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_control_ff) <= pimdc_pkg::SAT_HI &&
                        $signed(rsp_control_ff) >= pimdc_pkg::SAT_LO))
      else $error("control word outside saturation range");

   a_duty_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pimdc_pkg::ST_DDIV |-> div_rem_ff < pimdc_pkg::DUTY_DIV)
      else $error("duty divider remainder out of range");

   a_accept_starts_pi: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == pimdc_pkg::ST_PI && cnt_ff == 5'd0)
      else $error("accepted word did not start the PI multiply");

   a_pi_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pimdc_pkg::ST_PI |-> cnt_ff <= pimdc_pkg::PI_LAST)
      else $error("PI step counter overran");
`endif

endmodule
